// ----- sv/omx_pkg.sv -----
// ----------------------------------------------------------------------------
// omx_pkg
// shared types and constants of the x-drive wheel mixer
// ----------------------------------------------------------------------------
package omx_pkg;

   // register map
   typedef enum logic [1:0] {
      REG_DEADBAND    = 2'd0,
      REG_SPIN_RATE   = 2'd1,
      REG_TOP_SPEED   = 2'd2,
      REG_DRIVE_LIMIT = 2'd3
   } reg_index_type;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [6:0] DEADBAND_RST    = 7'd15;
   localparam logic [7:0] SPIN_RATE_RST   = 8'd140;
   localparam logic [7:0] TOP_SPEED_RST   = 8'd200;
   localparam logic [7:0] DRIVE_LIMIT_RST = 8'd255;

   // stick map: ((v + 127) * top) / 127 by reciprocal multiply
   localparam logic [8:0]  AXIS_OFFSET  = 9'd127;
   localparam logic [16:0] RECIP_127    = 17'd66053;
   localparam int unsigned RECIP_SHIFT  = 23;

   localparam int unsigned WHEELS   = 4;
   localparam int unsigned MAG_W    = 10;
   localparam int unsigned NUM_W    = 18;
   localparam int unsigned DRIVE_W  = 8;
   localparam int unsigned DIV_STEPS = DRIVE_W;

   // pipeline stage numbers
   localparam int unsigned ST_AXIS  = 0;
   localparam int unsigned ST_PROD  = 1;
   localparam int unsigned ST_RECIP = 2;
   localparam int unsigned ST_SPEED = 3;
   localparam int unsigned ST_MIX   = 4;
   localparam int unsigned ST_NORM  = 5;
   localparam int unsigned ST_DIV0  = 6;
   localparam int unsigned ST_OUT   = ST_DIV0 + DIV_STEPS;
   localparam int unsigned N_STAGES = ST_OUT + 1;

   typedef struct packed {
      logic [DIV_STEPS-1:0] step_en;
   } div_ctl_type;

   typedef struct packed {
      logic [NUM_W-1:0]   num;
      logic [MAG_W-1:0]   den;
      logic               scale;
      logic [DRIVE_W-1:0] mag;
   } div_in_type;

endpackage

// ----- sv/omx_req_if.sv -----
// ----------------------------------------------------------------------------
// omx_req_if
// request channel: one stick sample and the two rotate buttons
// ----------------------------------------------------------------------------
interface omx_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] stick_x;
   logic signed [7:0] stick_y;
   logic              rotate_ccw;
   logic              rotate_cw;

   modport source (output valid, stick_x, stick_y, rotate_ccw, rotate_cw, input ready);
   modport sink   (input valid, stick_x, stick_y, rotate_ccw, rotate_cw, output ready);
endinterface

// ----- sv/omx_rsp_if.sv -----
// ----------------------------------------------------------------------------
// omx_rsp_if
// result channel: direction and drive of the four wheels
// ----------------------------------------------------------------------------
interface omx_rsp_if;
   logic       valid;
   logic       ready;
   logic       wheel1_forward;
   logic [7:0] wheel1_drive;
   logic       wheel2_forward;
   logic [7:0] wheel2_drive;
   logic       wheel3_forward;
   logic [7:0] wheel3_drive;
   logic       wheel4_forward;
   logic [7:0] wheel4_drive;

   modport source (output valid, wheel1_forward, wheel1_drive, wheel2_forward, wheel2_drive,
                   wheel3_forward, wheel3_drive, wheel4_forward, wheel4_drive,
                   input ready);
   modport sink   (input valid, wheel1_forward, wheel1_drive, wheel2_forward, wheel2_drive,
                   wheel3_forward, wheel3_drive, wheel4_forward, wheel4_drive,
                   output ready);
endinterface

// ----- sv/omx_div_lane.sv -----
// ----------------------------------------------------------------------------
// omx_div_lane
// pipelined restoring divider, one quotient bit per stage, for one wheel
// ----------------------------------------------------------------------------
module omx_div_lane
   import omx_pkg::*;
(
   input  logic               clock,
   input  div_ctl_type        ctl,
   input  div_in_type         din,
   output logic [DRIVE_W-1:0] drive
);

   logic [NUM_W-1:0]     rem_ff   [DIV_STEPS];
   logic [MAG_W-1:0]     den_ff   [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff   [DIV_STEPS];
   logic                 scale_ff [DIV_STEPS];
   logic [DRIVE_W-1:0]   mag_ff   [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      localparam int unsigned Bit = DIV_STEPS - 1 - j;

      logic [NUM_W-1:0]     rem_src;
      logic [MAG_W-1:0]     den_src;
      logic [DIV_STEPS-1:0] quo_src;
      logic                 scale_src;
      logic [DRIVE_W-1:0]   mag_src;
      logic [NUM_W:0]       trial;
      logic [NUM_W-1:0]     rem_in;
      logic [DIV_STEPS-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_src   = din.num;
         assign den_src   = din.den;
         assign quo_src   = '0;
         assign scale_src = din.scale;
         assign mag_src   = din.mag;
      end else begin : g_next
         assign rem_src   = rem_ff[j-1];
         assign den_src   = den_ff[j-1];
         assign quo_src   = quo_ff[j-1];
         assign scale_src = scale_ff[j-1];
         assign mag_src   = mag_ff[j-1];
      end

      assign trial  = {1'b0, rem_src} - ({{(NUM_W + 1 - MAG_W){1'b0}}, den_src} << Bit);
      assign rem_in = trial[NUM_W] ? rem_src : trial[NUM_W-1:0];
      assign quo_in = quo_src | ({{(DIV_STEPS - 1){1'b0}}, !trial[NUM_W]} << Bit);

      always_ff @(posedge clock) begin
         if (ctl.step_en[j]) begin
            rem_ff[j]   <= rem_in;
            den_ff[j]   <= den_src;
            quo_ff[j]   <= quo_in;
            scale_ff[j] <= scale_src;
            mag_ff[j]   <= mag_src;
         end
      end
   end

   assign drive = scale_ff[DIV_STEPS-1] ? quo_ff[DIV_STEPS-1] : mag_ff[DIV_STEPS-1];

endmodule

// ----- sv/omni_x_drive_mixer.sv -----
// ----------------------------------------------------------------------------
// omni_x_drive_mixer
// x-drive wheel mixer: stick and rotate buttons to four wheel commands
// ----------------------------------------------------------------------------
// One request (stick x/y, rotate buttons) enters per clock unless the first
// stage is held, and its four wheel commands leave from the output register.
// The pipeline is: deadband and offset, map multiply, reciprocal multiply for
// the divide by 127, speed offset, wheel mix, peak search with scale products,
// then eight divider stages that each settle one quotient bit of
// |m| * drive_limit / peak, then the output register. Stages only hold when
// the stage after them is full and held, so requests keep flowing into empty
// slots while a result waits on rsp_bus. The registers are written through
// the csr_ port at byte offsets 0, 4, 8 and 12 (deadband, spin_rate,
// top_speed, drive_limit) and must only change while the block is empty.
// ----------------------------------------------------------------------------
module omni_x_drive_mixer
   import omx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   omx_req_if.sink               req_bus,
   omx_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic [6:0] deadband_ff;
   logic [7:0] spin_rate_ff;
   logic [7:0] top_speed_ff;
   logic [7:0] drive_limit_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff    <= DEADBAND_RST;
         spin_rate_ff   <= SPIN_RATE_RST;
         top_speed_ff   <= TOP_SPEED_RST;
         drive_limit_ff <= DRIVE_LIMIT_RST;
      end else if (csr_write) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_DEADBAND:    deadband_ff    <= csr_pwdata[6:0];
            REG_SPIN_RATE:   spin_rate_ff   <= csr_pwdata[7:0];
            REG_TOP_SPEED:   top_speed_ff   <= csr_pwdata[7:0];
            REG_DRIVE_LIMIT: drive_limit_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_DEADBAND:    csr_prdata = {{(CSR_DATA_W - 7){1'b0}}, deadband_ff};
         REG_SPIN_RATE:   csr_prdata = {{(CSR_DATA_W - 8){1'b0}}, spin_rate_ff};
         REG_TOP_SPEED:   csr_prdata = {{(CSR_DATA_W - 8){1'b0}}, top_speed_ff};
         REG_DRIVE_LIMIT: csr_prdata = {{(CSR_DATA_W - 8){1'b0}}, drive_limit_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // pipeline flow control
   logic [N_STAGES-1:0] valid_ff;
   logic [N_STAGES-1:0] valid_in;
   logic [N_STAGES:0]   en;

   always_comb begin
      en[N_STAGES] = rsp_bus.ready;
      for (int k = N_STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign valid_in      = {valid_ff[N_STAGES-2:0], req_bus.valid};
   assign req_bus.ready = en[ST_AXIS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < N_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // axis stage: deadband, offset, omega
   logic [7:0]        x_abs, y_abs;
   logic [7:0]        x_dz, y_dz;
   logic signed [8:0] tx_in, ty_in, w_in;
   logic signed [8:0] tx_ff, ty_ff, w0_ff;

   assign x_abs = req_bus.stick_x[7] ? 8'(-req_bus.stick_x) : 8'(req_bus.stick_x);
   assign y_abs = req_bus.stick_y[7] ? 8'(-req_bus.stick_y) : 8'(req_bus.stick_y);
   assign x_dz  = (x_abs < {1'b0, deadband_ff}) ? 8'd0 : req_bus.stick_x;
   assign y_dz  = (y_abs < {1'b0, deadband_ff}) ? 8'd0 : req_bus.stick_y;
   assign tx_in = {x_dz[7], x_dz} + AXIS_OFFSET;
   assign ty_in = {y_dz[7], y_dz} + AXIS_OFFSET;

   always_comb begin
      w_in = '0;
      if (req_bus.rotate_ccw) begin
         w_in = {1'b0, spin_rate_ff};
      end
      if (req_bus.rotate_cw) begin
         w_in = -{1'b0, spin_rate_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_AXIS]) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         w0_ff <= w_in;
      end
   end

   // product stage: |t| * top_speed
   logic [7:0]  tx_abs, ty_abs;
   logic [15:0] nx_ff, ny_ff;
   logic        negx1_ff, negy1_ff;
   logic signed [8:0] w1_ff;

   assign tx_abs = tx_ff[8] ? 8'(-tx_ff) : tx_ff[7:0];
   assign ty_abs = ty_ff[8] ? 8'(-ty_ff) : ty_ff[7:0];

   always_ff @(posedge clock) begin
      if (en[ST_PROD]) begin
         nx_ff    <= tx_abs * top_speed_ff;
         ny_ff    <= ty_abs * top_speed_ff;
         negx1_ff <= tx_ff[8];
         negy1_ff <= ty_ff[8];
         w1_ff    <= w0_ff;
      end
   end

   // reciprocal stage: n / 127
   logic [32:0] rx_prod, ry_prod;
   logic [8:0]  qx_ff, qy_ff;
   logic        negx2_ff, negy2_ff;
   logic signed [8:0] w2_ff;

   assign rx_prod = nx_ff * RECIP_127;
   assign ry_prod = ny_ff * RECIP_127;

   always_ff @(posedge clock) begin
      if (en[ST_RECIP]) begin
         qx_ff    <= 9'(rx_prod >> RECIP_SHIFT);
         qy_ff    <= 9'(ry_prod >> RECIP_SHIFT);
         negx2_ff <= negx1_ff;
         negy2_ff <= negy1_ff;
         w2_ff    <= w1_ff;
      end
   end

   // speed stage: signed quotient minus top_speed
   logic signed [9:0] qx_s, qy_s;
   logic signed [9:0] vs_ff, vf_ff;
   logic signed [8:0] w3_ff;

   assign qx_s = negx2_ff ? -{1'b0, qx_ff} : {1'b0, qx_ff};
   assign qy_s = negy2_ff ? -{1'b0, qy_ff} : {1'b0, qy_ff};

   always_ff @(posedge clock) begin
      if (en[ST_SPEED]) begin
         vs_ff <= qx_s - {2'b00, top_speed_ff};
         vf_ff <= qy_s - {2'b00, top_speed_ff};
         w3_ff <= w2_ff;
      end
   end

   // mix stage
   logic signed [11:0] vf_x, vs_x, w_x;
   logic signed [11:0] mix [WHEELS];
   logic [MAG_W-1:0]   mag_ff [WHEELS];
   logic [WHEELS-1:0]  fwd4_ff;

   assign vf_x = {{2{vf_ff[9]}}, vf_ff};
   assign vs_x = {{2{vs_ff[9]}}, vs_ff};
   assign w_x  = {{3{w3_ff[8]}}, w3_ff};

   assign mix[0] = vf_x + vs_x + w_x;
   assign mix[1] = vf_x - vs_x - w_x;
   assign mix[2] = vf_x + vs_x - w_x;
   assign mix[3] = vf_x - vs_x + w_x;

   always_ff @(posedge clock) begin
      if (en[ST_MIX]) begin
         for (int i = 0; i < WHEELS; i++) begin
            mag_ff[i]  <= mix[i][11] ? MAG_W'(-mix[i]) : MAG_W'(mix[i]);
            fwd4_ff[i] <= !mix[i][11];
         end
      end
   end

   // normalize stage: peak, scale decision and scale products
   logic [MAG_W-1:0]  peak_a, peak_b, peak;
   logic [MAG_W-1:0]  den5_ff;
   logic              scale5_ff;
   logic [NUM_W-1:0]  num5_ff [WHEELS];
   logic [DRIVE_W-1:0] mag5_ff [WHEELS];
   logic [WHEELS-1:0] fwd5_ff;

   assign peak_a = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign peak_b = (mag_ff[2] > mag_ff[3]) ? mag_ff[2] : mag_ff[3];
   assign peak   = (peak_a > peak_b) ? peak_a : peak_b;

   always_ff @(posedge clock) begin
      if (en[ST_NORM]) begin
         den5_ff   <= peak;
         scale5_ff <= peak > {{(MAG_W - DRIVE_W){1'b0}}, drive_limit_ff};
         fwd5_ff   <= fwd4_ff;
         for (int i = 0; i < WHEELS; i++) begin
            num5_ff[i] <= mag_ff[i] * drive_limit_ff;
            mag5_ff[i] <= mag_ff[i][DRIVE_W-1:0];
         end
      end
   end

   // divider lanes
   div_ctl_type        div_ctl;
   logic [DRIVE_W-1:0] lane_drive [WHEELS];
   logic [WHEELS-1:0]  fwd_pipe_ff [DIV_STEPS];

   assign div_ctl.step_en = en[ST_DIV0 +: DIV_STEPS];

   for (genvar i = 0; i < WHEELS; i++) begin : g_lane
      div_in_type lane_in;

      assign lane_in.num   = num5_ff[i];
      assign lane_in.den   = den5_ff;
      assign lane_in.scale = scale5_ff;
      assign lane_in.mag   = mag5_ff[i];

      omx_div_lane u_lane (
         .clock (clock),
         .ctl   (div_ctl),
         .din   (lane_in),
         .drive (lane_drive[i])
      );
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (en[ST_DIV0 + j]) begin
            fwd_pipe_ff[j] <= (j == 0) ? fwd5_ff : fwd_pipe_ff[(j == 0) ? 0 : j - 1];
         end
      end
   end

   // output register
   logic [WHEELS-1:0]  out_fwd_ff;
   logic [DRIVE_W-1:0] out_drive_ff [WHEELS];

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         out_fwd_ff <= fwd_pipe_ff[DIV_STEPS-1];
         for (int i = 0; i < WHEELS; i++) begin
            out_drive_ff[i] <= lane_drive[i];
         end
      end
   end

   assign rsp_bus.valid          = valid_ff[ST_OUT];
   assign rsp_bus.wheel1_forward = out_fwd_ff[0];
   assign rsp_bus.wheel1_drive   = out_drive_ff[0];
   assign rsp_bus.wheel2_forward = out_fwd_ff[1];
   assign rsp_bus.wheel2_drive   = out_drive_ff[1];
   assign rsp_bus.wheel3_forward = out_fwd_ff[2];
   assign rsp_bus.wheel3_drive   = out_drive_ff[2];
   assign rsp_bus.wheel4_forward = out_fwd_ff[3];
   assign rsp_bus.wheel4_drive   = out_drive_ff[3];

`ifndef SYNTHESIS
   a_drive_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.wheel1_drive <= drive_limit_ff) &&
                        (rsp_bus.wheel2_drive <= drive_limit_ff) &&
                        (rsp_bus.wheel3_drive <= drive_limit_ff) &&
                        (rsp_bus.wheel4_drive <= drive_limit_ff))
      else $error("wheel drive above drive_limit");

   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[ST_OUT] |-> req_bus.ready)
      else $error("request stalled with empty output stage");

   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> valid_ff[ST_AXIS])
      else $error("accepted request not captured");

   a_scale_nonzero_den: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_NORM] && scale5_ff |-> den5_ff != '0)
      else $error("scaling with zero peak");
`endif

endmodule

// ----- tb/tb_omni_x_drive_mixer.sv -----
// ----------------------------------------------------------------------------
// tb_omni_x_drive_mixer
// self-checking bench for the x-drive wheel mixer
// ----------------------------------------------------------------------------
// A clocked driver feeds stick requests from a queue and predicts the four
// wheel commands of each accepted request against a shadow copy of the
// registers. A clocked monitor compares every result in order. A short
// directed part covers the stick extremes, the button combinations, the
// deadband edge and the zero and unit drive limits. Random phases follow,
// each under its own register setting, with random idling on both sides,
// one phase without idling and one long result hold-off that backs up the
// pipeline.
// ----------------------------------------------------------------------------
module tb_omni_x_drive_mixer;
   import omx_pkg::*;

   typedef struct packed {
      logic signed [7:0] stick_x;
      logic signed [7:0] stick_y;
      logic              rotate_ccw;
      logic              rotate_cw;
   } stick_req_type;

   typedef struct {
      logic       fwd [WHEELS];
      logic [7:0] drv [WHEELS];
   } wheel_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic              req_valid = 1'b0;
   logic signed [7:0] req_x     = '0;
   logic signed [7:0] req_y     = '0;
   logic              req_ccw   = 1'b0;
   logic              req_cw    = 1'b0;
   logic              rsp_ready = 1'b0;

   logic [6:0] deadband_cfg    = DEADBAND_RST;
   logic [7:0] spin_rate_cfg   = SPIN_RATE_RST;
   logic [7:0] top_speed_cfg   = TOP_SPEED_RST;
   logic [7:0] drive_limit_cfg = DRIVE_LIMIT_RST;

   stick_req_type pending_reqs [$];
   wheel_cmd_type expected_cmds [$];

   logic no_idle      = 1'b0;
   logic hold_trigger = 1'b0;
   int   hold_left    = 0;
   int   failures     = 0;

   omx_req_if req_if ();
   omx_rsp_if rsp_if ();

   assign req_if.valid      = req_valid;
   assign req_if.stick_x    = req_x;
   assign req_if.stick_y    = req_y;
   assign req_if.rotate_ccw = req_ccw;
   assign req_if.rotate_cw  = req_cw;
   assign rsp_if.ready      = rsp_ready;

   omni_x_drive_mixer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial forever #4 clock = ~clock;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #1600000;
      $display("tb: failure");
      $finish;
   end

   // deadband, then map to -top..top with truncating divide
   function automatic int axis_speed(logic signed [7:0] stick);
      int v;
      int top;
      v   = stick;
      top = top_speed_cfg;
      if (((v < 0) ? -v : v) < int'(deadband_cfg)) v = 0;
      return ((v + 127) * 2 * top) / 254 - top;
   endfunction

   function automatic wheel_cmd_type mix_wheels(stick_req_type r);
      wheel_cmd_type cmd;
      int vs;
      int vf;
      int omega;
      int lim;
      int peak;
      int d;
      int m   [WHEELS];
      int mag [WHEELS];
      vs    = axis_speed(r.stick_x);
      vf    = axis_speed(r.stick_y);
      lim   = drive_limit_cfg;
      omega = 0;
      if (r.rotate_ccw) omega = spin_rate_cfg;
      if (r.rotate_cw) omega = -int'(spin_rate_cfg);
      m[0] = vf + vs + omega;
      m[1] = vf - vs - omega;
      m[2] = vf + vs - omega;
      m[3] = vf - vs + omega;
      peak = 0;
      for (int i = 0; i < WHEELS; i++) begin
         mag[i] = (m[i] < 0) ? -m[i] : m[i];
         if (mag[i] > peak) peak = mag[i];
      end
      for (int i = 0; i < WHEELS; i++) begin
         d = mag[i];
         if (peak > lim) d = (d * lim) / peak;
         if (d > lim) d = lim;
         cmd.fwd[i] = (m[i] >= 0);
         cmd.drv[i] = d[7:0];
      end
      return cmd;
   endfunction

   task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0d got %0d", name, exp_v, act_v);
         failures++;
      end
   endtask

   // request driver and prediction on acceptance
   always @(posedge clock) begin
      stick_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_if.ready)
            expected_cmds.push_back(mix_wheels('{req_x, req_y, req_ccw, req_cw}));
         if (!req_valid || req_if.ready) begin
            if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= 14)) begin
               nxt = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_x     <= nxt.stick_x;
               req_y     <= nxt.stick_y;
               req_ccw   <= nxt.rotate_ccw;
               req_cw    <= nxt.rotate_cw;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long result hold-off
   always @(posedge clock) begin
      if (hold_trigger && hold_left == 0) hold_left <= 300;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // result monitor
   always @(posedge clock) begin
      wheel_cmd_type exp_cmd;
      wheel_cmd_type act_cmd;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 14);
         if (rsp_if.valid && rsp_ready) begin
            act_cmd.fwd = '{rsp_if.wheel1_forward, rsp_if.wheel2_forward,
                            rsp_if.wheel3_forward, rsp_if.wheel4_forward};
            act_cmd.drv = '{rsp_if.wheel1_drive, rsp_if.wheel2_drive,
                            rsp_if.wheel3_drive, rsp_if.wheel4_drive};
            if (expected_cmds.size() == 0) begin
               $error("wheel result with no request outstanding");
               failures++;
            end else begin
               exp_cmd = expected_cmds.pop_front();
               for (int i = 0; i < WHEELS; i++) begin
                  check_field($sformatf("wheel%0d_forward", i + 1),
                              {7'd0, exp_cmd.fwd[i]}, {7'd0, act_cmd.fwd[i]});
                  check_field($sformatf("wheel%0d_drive", i + 1),
                              exp_cmd.drv[i], act_cmd.drv[i]);
               end
            end
         end
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_cmds.size() != 0);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_DEADBAND:    deadband_cfg    = value[6:0];
         REG_SPIN_RATE:   spin_rate_cfg   = value[7:0];
         REG_TOP_SPEED:   top_speed_cfg   = value[7:0];
         REG_DRIVE_LIMIT: drive_limit_cfg = value[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(int db, int rot, int top, int lim);
      wait_idle();
      csr_write(REG_DEADBAND, db);
      csr_write(REG_SPIN_RATE, rot);
      csr_write(REG_TOP_SPEED, top);
      csr_write(REG_DRIVE_LIMIT, lim);
   endtask

   task automatic add_req(int x, int y, bit ccw, bit cw);
      pending_reqs.push_back('{x[7:0], y[7:0], ccw, cw});
   endtask

   // stick values biased toward the extremes and the deadband edge
   function automatic logic signed [7:0] pick_stick();
      int db;
      db = deadband_cfg;
      case ($urandom_range(9))
         0: return -8'sd128;
         1: return 8'sd127;
         2: return -8'sd127;
         3: return 8'sd0;
         4: return db[7:0];
         5: return 8'(-db);
         6: return 8'(db - 1);
         7: return 8'(1 - db);
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   initial begin
      int n_items;
      @(negedge reset);
      repeat (2) @(posedge clock);

      // directed, reset setting
      add_req(127, 127, 0, 0);
      add_req(-128, -128, 0, 0);
      add_req(-128, 127, 1, 0);
      add_req(127, -128, 0, 1);
      add_req(0, 0, 1, 1);
      add_req(0, 0, 1, 0);
      add_req(0, 0, 0, 1);
      add_req(14, -14, 0, 0);
      add_req(15, -15, 0, 0);
      add_req(-16, 16, 1, 1);
      add_req(127, 0, 1, 0);
      add_req(0, -128, 0, 1);
      add_req(-1, 1, 0, 0);
      add_req(64, -64, 1, 0);
      add_req(-100, 50, 0, 1);
      add_req(0, 0, 0, 0);

      // zero drive limit
      apply_setting(15, 140, 200, 0);
      add_req(127, 127, 1, 0);
      add_req(-128, 0, 0, 1);
      add_req(0, 0, 0, 0);

      // widest deadband, unit limit
      apply_setting(127, 255, 255, 1);
      add_req(127, -128, 1, 1);
      add_req(-128, 127, 0, 0);
      add_req(126, 0, 1, 0);

      // no deadband, no speed
      apply_setting(0, 0, 0, 128);
      add_req(0, 0, 0, 0);
      add_req(-128, -128, 1, 1);
      add_req(1, -1, 0, 0);

      // random phases
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_setting(15, 140, 200, 255);
            1: apply_setting(0, 255, 255, 255);
            2: apply_setting(127, 0, 0, 1);
            4: apply_setting(0, 255, 255, 1);
            default: apply_setting($urandom_range(127), $urandom_range(255),
                                   $urandom_range(255), $urandom_range(255, 1));
         endcase
         no_idle = (phase == 1);
         n_items = 94;
         for (int i = 0; i < n_items; i++)
            add_req(pick_stick(), pick_stick(), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
         if (phase == 3) begin
            @(posedge clock);
            hold_trigger <= 1'b1;
            @(posedge clock);
            hold_trigger <= 1'b0;
         end
      end

      wait_idle();
      no_idle = 1'b0;
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/omx_pkg.sv
sv/omx_req_if.sv
sv/omx_rsp_if.sv
sv/omx_div_lane.sv
sv/omni_x_drive_mixer.sv
tb/tb_omni_x_drive_mixer.sv
